/* rtl/vps_pkg.sv */
package vps_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_GRAVITY_X     = 3'd0,
        REG_GRAVITY_Y     = 3'd1,
        REG_DT_SQUARED    = 3'd2,
        REG_MAX_SPEED     = 3'd3,
        REG_DAMPING       = 3'd4,
        REG_WINDOW_WIDTH  = 3'd5,
        REG_WINDOW_HEIGHT = 3'd6
    } t_reg_idx;

    localparam logic [31:0] GRAVITY_X_RST = 32'd0;
    localparam longint      GRAVITY_Y_PIX = 1000;
    localparam logic [31:0] DT2_RST       = 32'd18641;
    localparam longint      MAX_SPEED_PIX = 5;
    localparam logic [15:0] DAMPING_RST   = 16'd49152;
    localparam logic [11:0] WINDOW_RST    = 12'd1000;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Saturation to 32 bits from a 40-bit signed intermediate.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic ovf32(input logic signed [39:0] v);
        return (v > 40'sd2147483647) || (v < -40'sd2147483648);
    endfunction

    typedef struct packed {
        logic               kind;
        logic               hs;
        logic               hf;
        logic               ovf;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic signed [33:0] tx;
        logic signed [33:0] ty;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_s1;

    typedef struct packed {
        logic               kind;
        logic               hs;
        logic               hf;
        logic               ovf;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic signed [33:0] tx;
        logic signed [33:0] ty;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [33:0] dmx;
        logic signed [33:0] dmy;
    } t_s2;

    typedef struct packed {
        logic               kind;
        logic               hs;
        logic               hf;
        logic               capped;
        logic               ovf;
        logic               sgnx;
        logic               sgny;
        logic signed [31:0] npx;
        logic signed [31:0] npy;
        logic signed [31:0] nqx;
        logic signed [31:0] nqy;
    } t_res;

endpackage

/* rtl/verlet_particle_substep.sv */
// Channel   Handshake                    Payload
// config    i_cfg_wr_en (write only)     i_cfg_idx, i_cfg_wdata
// input     i_in_valid / o_in_ready      i_kind, i_pos_*, i_prev_*, i_accel_*, i_ball_radius
// output    o_out_valid / i_out_ready    o_new_*, o_hit_*, o_speed_capped, o_overflowed
//
// One transaction is accepted per cycle while o_in_ready is high; each gives one result.
// The pipeline depth is set by the speed cap: a 32-step square root and a 31-step divider,
// one step per stage, after seven stages of add, multiply and compare.
// Reset is synchronous, clears the valid bits and loads the configuration registers with their defaults.
// A stalled output fills a two-entry output buffer; only when it is full does the
// whole pipeline hold and o_in_ready drop, so no transaction is lost or repeated.
module verlet_particle_substep #(
    parameter int FRAC_BITS = vps_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_prev_x,
    input  logic signed [31:0] i_prev_y,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic [23:0]        i_ball_radius,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_prev_x,
    output logic signed [31:0] o_new_prev_y,
    output logic               o_hit_side,
    output logic               o_hit_floor,
    output logic               o_speed_capped,
    output logic               o_overflowed
);

    localparam int SQS = vps_pkg::SQRT_STEPS;
    localparam int DVS = vps_pkg::DIV_STEPS;

    localparam longint GY_RAW = vps_pkg::GRAVITY_Y_PIX << FRAC_BITS;
    localparam logic [31:0] GY_RST = (GY_RAW > 64'sd2147483647) ? 32'h7FFF_FFFF
                                                                 : 32'(GY_RAW);
    localparam logic [30:0] MS_RST = 31'(vps_pkg::MAX_SPEED_PIX << FRAC_BITS);

    // Configuration registers.
    logic signed [31:0] r_gx, r_gy;
    logic [31:0]        r_dt2;
    logic [30:0]        r_mx;
    logic [15:0]        r_damp;
    logic [11:0]        r_win_w, r_win_h;
    logic [61:0]        r_msq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx    <= vps_pkg::GRAVITY_X_RST;
            r_gy    <= GY_RST;
            r_dt2   <= vps_pkg::DT2_RST;
            r_mx    <= MS_RST;
            r_damp  <= vps_pkg::DAMPING_RST;
            r_win_w <= vps_pkg::WINDOW_RST;
            r_win_h <= vps_pkg::WINDOW_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                vps_pkg::REG_GRAVITY_X:     r_gx    <= i_cfg_wdata;
                vps_pkg::REG_GRAVITY_Y:     r_gy    <= i_cfg_wdata;
                vps_pkg::REG_DT_SQUARED:    r_dt2   <= i_cfg_wdata;
                vps_pkg::REG_MAX_SPEED:     r_mx    <= i_cfg_wdata[30:0];
                vps_pkg::REG_DAMPING:       r_damp  <= i_cfg_wdata[15:0];
                vps_pkg::REG_WINDOW_WIDTH:  r_win_w <= i_cfg_wdata[11:0];
                vps_pkg::REG_WINDOW_HEIGHT: r_win_h <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // The squared limit follows the register; it settles long before an item needs it.
    always_ff @(posedge i_clk) begin
        r_msq <= r_mx * r_mx;
    end

    logic en;
    logic r_skid_v, r_out_v;
    assign en         = ~r_skid_v;
    assign o_in_ready = en;

    // Stage 1: acceleration with gravity, velocity, border tests and clamps.
    vps_pkg::t_s1 n_s1, r_s1;
    logic signed [39:0] ax40, ay40, r40, w40, h40, bx40, by40;
    logic lo_x, hi_x, lo_y, hi_y;

    always_comb begin
        ax40 = 40'(i_accel_x) + 40'(r_gx);
        ay40 = 40'(i_accel_y) + 40'(r_gy);
        r40  = $signed({16'd0, i_ball_radius});
        w40  = $signed(40'(r_win_w) << FRAC_BITS);
        h40  = $signed(40'(r_win_h) << FRAC_BITS);
        lo_x = (40'(i_pos_x) - r40) < 40'sd0;
        hi_x = (40'(i_pos_x) + r40) >= w40;
        lo_y = (40'(i_pos_y) - r40) < 40'sd0;
        hi_y = (40'(i_pos_y) + r40) >= h40;
        // The low clamp wins when the radius exceeds half the box.
        bx40 = lo_x ? r40 : (hi_x ? (w40 - r40) : 40'(i_pos_x));
        by40 = lo_y ? r40 : (hi_y ? (h40 - r40) : 40'(i_pos_y));
        n_s1.kind = i_kind;
        n_s1.hs   = i_kind & (lo_x | hi_x);
        n_s1.hf   = i_kind & (lo_y | hi_y);
        n_s1.ovf  = i_kind ? (vps_pkg::ovf32(bx40) | vps_pkg::ovf32(by40))
                           : (vps_pkg::ovf32(ax40) | vps_pkg::ovf32(ay40));
        n_s1.px   = i_pos_x;
        n_s1.py   = i_pos_y;
        n_s1.qx   = i_prev_x;
        n_s1.qy   = i_prev_y;
        n_s1.vx   = 33'(i_pos_x) - 33'(i_prev_x);
        n_s1.vy   = 33'(i_pos_y) - 33'(i_prev_y);
        n_s1.tx   = 34'(i_pos_x) + 34'(n_s1.vx);
        n_s1.ty   = 34'(i_pos_y) + 34'(n_s1.vy);
        n_s1.ax   = vps_pkg::sat32(ax40);
        n_s1.ay   = vps_pkg::sat32(ay40);
        n_s1.bx   = vps_pkg::sat32(bx40);
        n_s1.by   = vps_pkg::sat32(by40);
    end

    // Stage 2: acceleration times dt squared, and damped velocities.
    vps_pkg::t_s2 n_s2, r_s2;
    logic signed [64:0] prod_x, prod_y;
    logic signed [49:0] dmp_x, dmp_y;

    always_comb begin
        prod_x = r_s1.ax * $signed({1'b0, r_dt2});
        prod_y = r_s1.ay * $signed({1'b0, r_dt2});
        dmp_x  = r_s1.vx * $signed({1'b0, r_damp});
        dmp_y  = r_s1.vy * $signed({1'b0, r_damp});
        n_s2.kind = r_s1.kind;
        n_s2.hs   = r_s1.hs;
        n_s2.hf   = r_s1.hf;
        n_s2.ovf  = r_s1.ovf;
        n_s2.px   = r_s1.px;
        n_s2.py   = r_s1.py;
        n_s2.qx   = r_s1.qx;
        n_s2.qy   = r_s1.qy;
        n_s2.vx   = r_s1.vx;
        n_s2.vy   = r_s1.vy;
        n_s2.tx   = r_s1.tx;
        n_s2.ty   = r_s1.ty;
        n_s2.bx   = r_s1.bx;
        n_s2.by   = r_s1.by;
        n_s2.dx   = prod_x[63:32];
        n_s2.dy   = prod_y[63:32];
        n_s2.dmx  = dmp_x[49:16];
        n_s2.dmy  = dmp_y[49:16];
    end

    // Stage 3: new position and previous position before the speed cap.
    vps_pkg::t_res n_s3, r_s3;
    logic signed [31:0] r_s3_px, r_s3_py;
    logic signed [39:0] n0x, n0y, q40x, q40y;

    always_comb begin
        n0x = 40'(r_s2.tx) + 40'(r_s2.dx);
        n0y = 40'(r_s2.ty) + 40'(r_s2.dy);
        if (r_s2.hf) begin
            q40x = 40'(r_s2.bx) - 40'(r_s2.dmx);
            q40y = 40'(r_s2.by) + 40'(r_s2.vy);
        end else if (r_s2.hs) begin
            q40x = 40'(r_s2.bx) + 40'(r_s2.vx);
            q40y = 40'(r_s2.by) - 40'(r_s2.dmy);
        end else begin
            q40x = 40'(r_s2.qx);
            q40y = 40'(r_s2.qy);
        end
        n_s3.kind   = r_s2.kind;
        n_s3.hs     = r_s2.hs;
        n_s3.hf     = r_s2.hf;
        n_s3.capped = 1'b0;
        n_s3.sgnx   = 1'b0;
        n_s3.sgny   = 1'b0;
        if (!r_s2.kind) begin
            n_s3.npx = vps_pkg::sat32(n0x);
            n_s3.npy = vps_pkg::sat32(n0y);
            n_s3.nqx = r_s2.px;
            n_s3.nqy = r_s2.py;
            n_s3.ovf = r_s2.ovf | vps_pkg::ovf32(n0x) | vps_pkg::ovf32(n0y);
        end else begin
            n_s3.npx = r_s2.bx;
            n_s3.npy = r_s2.by;
            n_s3.nqx = vps_pkg::sat32(q40x);
            n_s3.nqy = vps_pkg::sat32(q40y);
            n_s3.ovf = r_s2.ovf | vps_pkg::ovf32(q40x) | vps_pkg::ovf32(q40y);
        end
    end

    // Stages 4 to 7: velocity, magnitude, cap test and squares for the length.
    vps_pkg::t_res r_s4, r_s5, r_s6, r_s7, n_s5, n_s7;
    logic signed [32:0] r_s4_cx, r_s4_cy;
    logic [32:0]        r_s5_ux, r_s5_uy;
    logic               r_s6_over;
    logic [61:0]        r_s6_sqx, r_s6_sqy;
    logic [31:0]        r_s6_hx, r_s6_hy, r_s7_hx, r_s7_hy;
    logic [63:0]        r_s7_hsqx, r_s7_hsqy;
    logic               halve, cap_test;
    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    assign halve    = r_s5_ux[32] | r_s5_ux[31] | r_s5_uy[32] | r_s5_uy[31];
    assign cap_test = r_s6_over | ((63'(r_s6_sqx) + 63'(r_s6_sqy)) > 63'(r_msq));

    // Square root and divider pipelines.
    logic [63:0]   r_sq_x  [0:SQS];
    logic [63:0]   r_sq_r  [0:SQS];
    logic [62:0]   r_sq_nx [0:SQS];
    logic [62:0]   r_sq_ny [0:SQS];
    vps_pkg::t_res r_sq_c  [0:SQS];
    logic          r_sq_v  [0:SQS];
    logic [63:0]   sq_rb   [0:SQS-1];

    logic [31:0]   r_dv_d  [0:DVS];
    logic [31:0]   r_dv_rx [0:DVS];
    logic [31:0]   r_dv_ry [0:DVS];
    logic [62:0]   r_dv_nx [0:DVS];
    logic [62:0]   r_dv_ny [0:DVS];
    logic [30:0]   r_dv_qx [0:DVS];
    logic [30:0]   r_dv_qy [0:DVS];
    vps_pkg::t_res r_dv_c  [0:DVS];
    logic          r_dv_v  [0:DVS];
    logic [32:0]   dv_tx   [0:DVS-1];
    logic [32:0]   dv_ty   [0:DVS-1];
    logic [30:0]   n_dv_qx [0:DVS-1];
    logic [30:0]   n_dv_qy [0:DVS-1];
    logic [31:0]   len;

    always_comb begin
        n_s5        = r_s4;
        n_s5.sgnx   = r_s4_cx[32];
        n_s5.sgny   = r_s4_cy[32];
        n_s7        = r_s6;
        n_s7.capped = ~r_s6.kind & cap_test;
        for (int k = 0; k < SQS; k++) begin
            sq_rb[k] = r_sq_r[k] + (64'd1 << (62 - 2 * k));
        end
        for (int i = 0; i < DVS; i++) begin
            dv_tx[i]   = {r_dv_rx[i], r_dv_nx[i][DVS - 1 - i]};
            dv_ty[i]   = {r_dv_ry[i], r_dv_ny[i][DVS - 1 - i]};
            n_dv_qx[i] = r_dv_qx[i];
            n_dv_qy[i] = r_dv_qy[i];
            if (dv_tx[i] >= {1'b0, r_dv_d[i]}) begin
                n_dv_qx[i][DVS - 1 - i] = 1'b1;
            end
            if (dv_ty[i] >= {1'b0, r_dv_d[i]}) begin
                n_dv_qy[i][DVS - 1 - i] = 1'b1;
            end
        end
        len = r_sq_r[SQS][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            for (int k = 0; k <= SQS; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int i = 0; i <= DVS; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else if (en) begin
            r_v1      <= i_in_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_sq_v[0] <= r_v7;
            for (int k = 0; k < SQS; k++) begin
                r_sq_v[k + 1] <= r_sq_v[k];
            end
            r_dv_v[0] <= r_sq_v[SQS];
            for (int i = 0; i < DVS; i++) begin
                r_dv_v[i + 1] <= r_dv_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_s3_px <= r_s2.px;
            r_s3_py <= r_s2.py;

            r_s4    <= r_s3;
            r_s4_cx <= 33'(r_s3.npx) - 33'(r_s3_px);
            r_s4_cy <= 33'(r_s3.npy) - 33'(r_s3_py);

            r_s5      <= n_s5;
            r_s5_ux   <= r_s4_cx[32] ? 33'(-r_s4_cx) : 33'(r_s4_cx);
            r_s5_uy   <= r_s4_cy[32] ? 33'(-r_s4_cy) : 33'(r_s4_cy);

            // The square test only matters when both magnitudes are within the limit.
            r_s6      <= r_s5;
            r_s6_over <= (r_s5_ux > 33'(r_mx)) | (r_s5_uy > 33'(r_mx));
            r_s6_sqx  <= r_s5_ux[30:0] * r_s5_ux[30:0];
            r_s6_sqy  <= r_s5_uy[30:0] * r_s5_uy[30:0];
            r_s6_hx   <= halve ? r_s5_ux[32:1] : r_s5_ux[31:0];
            r_s6_hy   <= halve ? r_s5_uy[32:1] : r_s5_uy[31:0];

            r_s7        <= n_s7;
            r_s7_hsqx   <= r_s6_hx * r_s6_hx;
            r_s7_hsqy   <= r_s6_hy * r_s6_hy;
            r_s7_hx     <= r_s6_hx;
            r_s7_hy     <= r_s6_hy;

            r_sq_x[0]  <= r_s7_hsqx + r_s7_hsqy;
            r_sq_r[0]  <= 64'd0;
            r_sq_nx[0] <= r_s7_hx * r_mx;
            r_sq_ny[0] <= r_s7_hy * r_mx;
            r_sq_c[0]  <= r_s7;
            for (int k = 0; k < SQS; k++) begin
                if (r_sq_x[k] >= sq_rb[k]) begin
                    r_sq_x[k + 1] <= r_sq_x[k] - sq_rb[k];
                    r_sq_r[k + 1] <= (r_sq_r[k] >> 1) + (64'd1 << (62 - 2 * k));
                end else begin
                    r_sq_x[k + 1] <= r_sq_x[k];
                    r_sq_r[k + 1] <= r_sq_r[k] >> 1;
                end
                r_sq_nx[k + 1] <= r_sq_nx[k];
                r_sq_ny[k + 1] <= r_sq_ny[k];
                r_sq_c[k + 1]  <= r_sq_c[k];
            end

            // A zero length only occurs with a zero velocity and divides by one.
            r_dv_d[0]  <= (len == 32'd0) ? 32'd1 : len;
            r_dv_rx[0] <= r_sq_nx[SQS][62:31];
            r_dv_ry[0] <= r_sq_ny[SQS][62:31];
            r_dv_nx[0] <= r_sq_nx[SQS];
            r_dv_ny[0] <= r_sq_ny[SQS];
            r_dv_qx[0] <= '0;
            r_dv_qy[0] <= '0;
            r_dv_c[0]  <= r_sq_c[SQS];
            for (int i = 0; i < DVS; i++) begin
                r_dv_d[i + 1]  <= r_dv_d[i];
                r_dv_nx[i + 1] <= r_dv_nx[i];
                r_dv_ny[i + 1] <= r_dv_ny[i];
                r_dv_c[i + 1]  <= r_dv_c[i];
                r_dv_qx[i + 1] <= n_dv_qx[i];
                r_dv_qy[i + 1] <= n_dv_qy[i];
                if (dv_tx[i] >= {1'b0, r_dv_d[i]}) begin
                    r_dv_rx[i + 1] <= 32'(dv_tx[i] - {1'b0, r_dv_d[i]});
                end else begin
                    r_dv_rx[i + 1] <= dv_tx[i][31:0];
                end
                if (dv_ty[i] >= {1'b0, r_dv_d[i]}) begin
                    r_dv_ry[i + 1] <= 32'(dv_ty[i] - {1'b0, r_dv_d[i]});
                end else begin
                    r_dv_ry[i + 1] <= dv_ty[i][31:0];
                end
            end
        end
    end

    // Last stage: previous position behind the capped velocity.
    vps_pkg::t_res n_push, r_out, r_skid;
    logic signed [39:0] sxs, sys, cqx, cqy;
    logic               push, pop;

    always_comb begin
        sxs = $signed({9'd0, r_dv_qx[DVS]});
        sys = $signed({9'd0, r_dv_qy[DVS]});
        if (r_dv_c[DVS].sgnx) begin
            sxs = -sxs;
        end
        if (r_dv_c[DVS].sgny) begin
            sys = -sys;
        end
        cqx    = 40'(r_dv_c[DVS].npx) - sxs;
        cqy    = 40'(r_dv_c[DVS].npy) - sys;
        n_push = r_dv_c[DVS];
        if (r_dv_c[DVS].capped) begin
            n_push.nqx = vps_pkg::sat32(cqx);
            n_push.nqy = vps_pkg::sat32(cqy);
            n_push.ovf = r_dv_c[DVS].ovf | vps_pkg::ovf32(cqx) | vps_pkg::ovf32(cqy);
        end
    end

    assign push = en & r_dv_v[DVS];
    assign pop  = r_out_v & i_out_ready;

    // Two-entry output buffer: the skid entry is filled only while the head waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= push;
            end else begin
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_v) begin
            if (r_skid_v) begin
                r_out  <= r_skid;
                r_skid <= n_push;
            end else begin
                r_out  <= n_push;
            end
        end else if (push) begin
            r_skid <= n_push;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_new_pos_x    = r_out.npx;
    assign o_new_pos_y    = r_out.npy;
    assign o_new_prev_x   = r_out.nqx;
    assign o_new_prev_y   = r_out.nqy;
    assign o_hit_side     = r_out.hs;
    assign o_hit_floor    = r_out.hf;
    assign o_speed_capped = r_out.capped;
    assign o_overflowed   = r_out.ovf;

endmodule

/* rtl/vps_checker.sv */
module vps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_wr_en,
    input logic [2:0]         i_cfg_idx,
    input logic [31:0]        i_cfg_wdata,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_kind,
    input logic signed [31:0] i_pos_x,
    input logic signed [31:0] i_pos_y,
    input logic signed [31:0] i_prev_x,
    input logic signed [31:0] i_prev_y,
    input logic signed [31:0] i_accel_x,
    input logic signed [31:0] i_accel_y,
    input logic [23:0]        i_ball_radius,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_new_pos_x,
    input logic signed [31:0] o_new_pos_y,
    input logic signed [31:0] o_new_prev_x,
    input logic signed [31:0] o_new_prev_y,
    input logic               o_hit_side,
    input logic               o_hit_floor,
    input logic               o_speed_capped,
    input logic               o_overflowed
);

    // A result that waits keeps its valid, its positions and its capped and overflow flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_pos_x)
            && $stable(o_new_pos_y) && $stable(o_new_prev_x) && $stable(o_new_prev_y)
            && $stable(o_speed_capped) && $stable(o_overflowed))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("buffer not empty after reset");

    // Input stalls only when the output buffer is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output");

    // A wall hit comes from the border kind, a speed cap from the integrate kind.
    a_kind_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_speed_capped && (o_hit_side || o_hit_floor)))
        else $error("speed cap and wall hit in one result");

endmodule

bind verlet_particle_substep vps_checker u_vps_checker (.*);

/* sim/verlet_particle_substep_test.sv */
`timescale 1ns / 1ps

module verlet_particle_substep_test;

    localparam int  FB           = 16;
    localparam int  SETTLE       = 90;
    localparam int  STALL_LIMIT  = 5000;
    localparam int  BACKPRESSURE = 400;

    typedef struct {
        logic               kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [23:0]        r;
    } t_particle;

    typedef struct {
        logic signed [31:0] npx;
        logic signed [31:0] npy;
        logic signed [31:0] nqx;
        logic signed [31:0] nqy;
        logic               hs;
        logic               hf;
        logic               capped;
        logic               ovf;
    } t_substep;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_kind;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_prev_x;
    logic signed [31:0] i_prev_y;
    logic signed [31:0] i_accel_x;
    logic signed [31:0] i_accel_y;
    logic [23:0]        i_ball_radius;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_new_pos_x;
    logic signed [31:0] o_new_pos_y;
    logic signed [31:0] o_new_prev_x;
    logic signed [31:0] o_new_prev_y;
    logic               o_hit_side;
    logic               o_hit_floor;
    logic               o_speed_capped;
    logic               o_overflowed;

    verlet_particle_substep dut (.*);

    // Shadow copy of the configuration registers.
    longint grav_x, grav_y, dt_sq, speed_lim, damp_k, win_w, win_h;

    t_substep pending_substeps[$];
    int       fail_count;
    int       idle_cycles;
    bit       quiet;
    int       hold_req;
    int       hold_seen;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint clip32(longint v, inout bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic t_substep predict_substep(t_particle p);
        t_substep s;
        bit     ovf, hs, hf, cap;
        longint px, py, qx, qy, vx, vy, npx, npy, nqx, nqy;
        longint ax, ay, dx, dy, cx, cy, ux, uy, len, sx, sy, r, w, h;
        ovf = 0; hs = 0; hf = 0; cap = 0;
        px = p.px; py = p.py; qx = p.qx; qy = p.qy;
        vx = px - qx;
        vy = py - qy;
        if (p.kind == 1'b0) begin
            ax = clip32(longint'(p.ax) + grav_x, ovf);
            ay = clip32(longint'(p.ay) + grav_y, ovf);
            dx = (ax * dt_sq) >>> 32;
            dy = (ay * dt_sq) >>> 32;
            npx = clip32(px + vx + dx, ovf);
            npy = clip32(py + vy + dy, ovf);
            nqx = px;
            nqy = py;
            cx = npx - px;
            cy = npy - py;
            ux = cx < 0 ? -cx : cx;
            uy = cy < 0 ? -cy : cy;
            if (ux > speed_lim || uy > speed_lim) cap = 1;
            else if (ux * ux + uy * uy > speed_lim * speed_lim) cap = 1;
            if (cap) begin
                if (ux >= 64'sd2147483648 || uy >= 64'sd2147483648) begin
                    ux = ux >>> 1;
                    uy = uy >>> 1;
                end
                len = int_sqrt(ux * ux + uy * uy);
                if (len == 0) len = 1;
                sx = ux * speed_lim / len;
                sy = uy * speed_lim / len;
                nqx = clip32(npx - (cx < 0 ? -sx : sx), ovf);
                nqy = clip32(npy - (cy < 0 ? -sy : sy), ovf);
            end
        end else begin
            r = p.r;
            w = win_w <<< FB;
            h = win_h <<< FB;
            npx = px; npy = py; nqx = qx; nqy = qy;
            if (px - r < 0) begin
                hs = 1;
                npx = clip32(r, ovf);
            end else if (px + r >= w) begin
                hs = 1;
                npx = clip32(w - r, ovf);
            end
            if (py - r < 0) begin
                hf = 1;
                npy = clip32(r, ovf);
            end else if (py + r >= h) begin
                hf = 1;
                npy = clip32(h - r, ovf);
            end
            // A floor hit decides the velocity even when a side wall was hit too.
            if (hf) begin
                nqx = clip32(npx - ((vx * damp_k) >>> 16), ovf);
                nqy = clip32(npy + vy, ovf);
            end else if (hs) begin
                nqx = clip32(npx + vx, ovf);
                nqy = clip32(npy - ((vy * damp_k) >>> 16), ovf);
            end
        end
        s.npx = npx[31:0];
        s.npy = npy[31:0];
        s.nqx = nqx[31:0];
        s.nqy = nqy[31:0];
        s.hs = hs;
        s.hf = hf;
        s.capped = cap;
        s.ovf = ovf;
        return s;
    endfunction

    task automatic write_reg(vps_pkg::t_reg_idx idx, logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            vps_pkg::REG_GRAVITY_X:     grav_x = longint'(signed'(value));
            vps_pkg::REG_GRAVITY_Y:     grav_y = longint'(signed'(value));
            vps_pkg::REG_DT_SQUARED:    dt_sq = value;
            vps_pkg::REG_MAX_SPEED:     speed_lim = value[30:0];
            vps_pkg::REG_DAMPING:       damp_k = value[15:0];
            vps_pkg::REG_WINDOW_WIDTH:  win_w = value[11:0];
            vps_pkg::REG_WINDOW_HEIGHT: win_h = value[11:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] gx, logic [31:0] gy, logic [31:0] dt2,
                             logic [31:0] ms, logic [31:0] dk,
                             logic [31:0] w, logic [31:0] h);
        write_reg(vps_pkg::REG_GRAVITY_X, gx);
        write_reg(vps_pkg::REG_GRAVITY_Y, gy);
        write_reg(vps_pkg::REG_DT_SQUARED, dt2);
        write_reg(vps_pkg::REG_MAX_SPEED, ms);
        write_reg(vps_pkg::REG_DAMPING, dk);
        write_reg(vps_pkg::REG_WINDOW_WIDTH, w);
        write_reg(vps_pkg::REG_WINDOW_HEIGHT, h);
    endtask

    task automatic send_particle(t_particle p);
        while (!quiet && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= p.kind;
        i_pos_x       <= p.px;
        i_pos_y       <= p.py;
        i_prev_x      <= p.qx;
        i_prev_y      <= p.qy;
        i_accel_x     <= p.ax;
        i_accel_y     <= p.ay;
        i_ball_radius <= p.r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_substeps = {pending_substeps, predict_substep(p)};
    endtask

    // Lets the pipeline empty completely; every item yields a result.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_substeps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_particle any_particle();
        t_particle p;
        p.kind = 1'($urandom_range(1));
        p.px = $urandom; p.py = $urandom;
        p.qx = $urandom; p.qy = $urandom;
        p.ax = $urandom; p.ay = $urandom;
        p.r  = 24'($urandom);
        return p;
    endfunction

    // A particle near or inside the box, moving a few pixels per step.
    function automatic t_particle box_particle();
        t_particle p;
        longint span_x, span_y;
        span_x = (win_w + 20) <<< FB;
        span_y = (win_h + 20) <<< FB;
        p.kind = 1'($urandom_range(1));
        p.px = 32'(longint'($urandom_range(span_x[31:0])) - (10 <<< FB));
        p.py = 32'(longint'($urandom_range(span_y[31:0])) - (10 <<< FB));
        p.qx = p.px - ($signed($urandom_range(20 << FB)) - (10 << FB));
        p.qy = p.py - ($signed($urandom_range(20 << FB)) - (10 << FB));
        p.ax = $signed($urandom_range(4000 << FB)) - (2000 << FB);
        p.ay = $signed($urandom_range(4000 << FB)) - (2000 << FB);
        p.r  = 24'($urandom_range(255 << FB));
        return p;
    endfunction

    function automatic t_particle mixed_particle();
        return ($urandom_range(99) < 75) ? box_particle() : any_particle();
    endfunction

    function automatic t_particle mk(logic kind, longint px, longint py, longint qx,
                                     longint qy, longint ax, longint ay, longint r);
        t_particle p;
        p.kind = kind;
        p.px = px[31:0]; p.py = py[31:0];
        p.qx = qx[31:0]; p.qy = qy[31:0];
        p.ax = ax[31:0]; p.ay = ay[31:0];
        p.r = r[23:0];
        return p;
    endfunction

    task automatic test_directed;
        longint mx, mn, c, r;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        c = 500 <<< FB;
        r = 10 <<< FB;
        // Integration: at rest, slow, fast enough to be capped, and saturating corners.
        send_particle(mk(0, c, c, c, c, 0, 0, 0));
        send_particle(mk(0, c, c, c - (2 <<< FB), c + (1 <<< FB), 0, 0, 0));
        send_particle(mk(0, c, c, c - (40 <<< FB), c + (30 <<< FB), 0, 0, 0));
        send_particle(mk(0, mx, mx, mn, mn, mx, mx, 0));
        send_particle(mk(0, mn, mn, mx, mx, mn, mn, 24'hFFFFFF));
        send_particle(mk(0, mx, mn, mx, mn, mn, mx, 0));
        send_particle(mk(0, 0, 0, 0, 0, mx, mx, 0));
        // Borders: each wall, a corner, no hit, and the largest radius.
        send_particle(mk(1, 5 <<< FB, c, 7 <<< FB, c + (2 <<< FB), 0, 0, r));
        send_particle(mk(1, 995 <<< FB, c, 993 <<< FB, c - (3 <<< FB), 0, 0, r));
        send_particle(mk(1, c, 2 <<< FB, c - (1 <<< FB), 5 <<< FB, 0, 0, r));
        send_particle(mk(1, c, 999 <<< FB, c + (4 <<< FB), 996 <<< FB, 0, 0, r));
        send_particle(mk(1, 1 <<< FB, 1 <<< FB, 3 <<< FB, 4 <<< FB, 0, 0, r));
        send_particle(mk(1, c, c, c - 1, c + 1, 0, 0, r));
        send_particle(mk(1, c, c, c, c, 0, 0, 24'hFFFFFF));
        send_particle(mk(1, c, c, c, c, 0, 0, 24'hFFFFFF));
        send_particle(mk(1, mn, mn, mx, mx, mn, mx, 24'hFFFFFF));
        send_particle(mk(1, mx, mx, mn, mn, mx, mn, 0));
        send_particle(mk(1, 0, 0, 0, 0, 0, 0, 0));
        send_particle(mk(1, c, c, c, c, 0, 0, 0));
        drain();
    endtask

    task automatic test_config_extremes;
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                             32'h0000_FFFF, 32'd4095, 32'd4095);
                1: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0,
                             32'd0, 32'd1, 32'd1);
                2: write_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF, 32'd1, 32'd4095);
                3: write_all(32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 32'h0040_0000,
                             32'h8000, 32'd4095, 32'd1);
                default: write_all($urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom_range(4095, 1),
                                   $urandom_range(4095, 1));
            endcase
            // The first settings run back to back with no idling at all.
            quiet = (k < 2);
            repeat (40) send_particle(mixed_particle());
            drain();
        end
        quiet = 0;
    endtask

    task automatic test_backpressure;
        write_all(32'd0, 32'h03E8_0000, 32'd18641, 32'h0005_0000, 32'hC000, 32'd1000,
                  32'd1000);
        hold_req++;
        repeat (150) send_particle(mixed_particle());
        drain();
    endtask

    task automatic test_random;
        for (int k = 0; k < 6; k++) begin
            write_all($urandom_range(99) < 50 ? $urandom : $signed($urandom_range(4000)),
                      $signed($urandom_range(4000 << FB)) - (2000 << FB),
                      $urandom_range(99) < 50 ? $urandom_range(100000) : $urandom,
                      $urandom_range(99) < 50 ? $urandom_range(20 << FB) : $urandom,
                      $urandom, $urandom_range(4095, 1), $urandom_range(4095, 1));
            repeat (110) send_particle(mixed_particle());
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            i_out_ready <= 1'b0;
            repeat (BACKPRESSURE - 1) @(posedge i_clk);
        end
        i_out_ready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        t_substep e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_substeps.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                e = pending_substeps.pop_front();
                if (o_new_pos_x !== e.npx) begin
                    $error("new_pos_x expected %0d actual %0d", e.npx, o_new_pos_x);
                    fail_count++;
                end
                if (o_new_pos_y !== e.npy) begin
                    $error("new_pos_y expected %0d actual %0d", e.npy, o_new_pos_y);
                    fail_count++;
                end
                if (o_new_prev_x !== e.nqx) begin
                    $error("new_prev_x expected %0d actual %0d", e.nqx, o_new_prev_x);
                    fail_count++;
                end
                if (o_new_prev_y !== e.nqy) begin
                    $error("new_prev_y expected %0d actual %0d", e.nqy, o_new_prev_y);
                    fail_count++;
                end
                if (o_hit_side !== e.hs) begin
                    $error("hit_side expected %0d actual %0d", e.hs, o_hit_side);
                    fail_count++;
                end
                if (o_hit_floor !== e.hf) begin
                    $error("hit_floor expected %0d actual %0d", e.hf, o_hit_floor);
                    fail_count++;
                end
                if (o_speed_capped !== e.capped) begin
                    $error("speed_capped expected %0d actual %0d", e.capped,
                           o_speed_capped);
                    fail_count++;
                end
                if (o_overflowed !== e.ovf) begin
                    $error("overflowed expected %0d actual %0d", e.ovf, o_overflowed);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        quiet         = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_kind        = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_prev_x      = '0;
        i_prev_y      = '0;
        i_accel_x     = '0;
        i_accel_y     = '0;
        i_ball_radius = '0;
        grav_x    = 0;
        grav_y    = 1000 <<< FB;
        dt_sq     = 18641;
        speed_lim = 5 <<< FB;
        damp_k    = 49152;
        win_w     = 1000;
        win_h     = 1000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vps_pkg.sv
rtl/verlet_particle_substep.sv
rtl/vps_checker.sv
sim/verlet_particle_substep_test.sv
